FILE: rtl/bra_pkg.sv
// Shared constants, codes and types of the block range allocator.
`default_nettype none
package bra_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_FIRST = 2'd0;
  localparam opcode_t OP_BEST  = 2'd1;
  localparam opcode_t OP_WORST = 2'd2;
  localparam opcode_t OP_FREE  = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_SIZE = 2'd1;
  localparam status_t ST_NO_SPACE = 2'd2;
  localparam status_t ST_BAD_FREE = 2'd3;

  localparam logic [CNT_W-1:0] MAX_REQUEST = 9'd256;
  localparam logic [CNT_W-1:0] SPARE_LIMIT = 9'd1;

  typedef struct packed {
    logic clear;
    logic step;
    logic free_bit;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] len;
  } run_t;

endpackage
`default_nettype wire

FILE: rtl/bra_map.sv
// Free map as a circular shift register, one block bit per cycle at the head while shift is high.
`default_nettype none
module bra_map (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift,
  input  wire logic wr_bit,
  output logic      head_bit
);
  import bra_pkg::*;

  logic [NUM_BLOCKS-1:0] map_r;

  // Rotate toward the head; the written bit re-enters at the tail.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '1;
    end else if (shift) begin
      map_r <= {wr_bit, map_r[NUM_BLOCKS-1:1]};
    end
  end

  assign head_bit = map_r[0];

endmodule
`default_nettype wire

FILE: rtl/bra_runs.sv
// Serial free-run tracker that keeps the chosen run for first, best or worst fit.
`default_nettype none
module bra_runs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bra_pkg::scan_ctl_t          ctl,
  input  wire bra_pkg::opcode_t            mode,
  input  wire logic [bra_pkg::CNT_W-1:0]   need,
  input  wire logic [bra_pkg::IDX_W-1:0]   pos,
  output bra_pkg::run_t                    run
);
  import bra_pkg::*;

  logic             found_r;
  logic [CNT_W-1:0] cur_l_r;
  logic [IDX_W-1:0] cur_s_r;
  logic [IDX_W-1:0] best_s_r;
  logic [CNT_W-1:0] best_l_r;
  logic             take;

  always_comb begin
    take = (cur_l_r >= need) &&
           (!found_r ||
            ((mode == OP_BEST)  && (cur_l_r < best_l_r)) ||
            ((mode == OP_WORST) && (cur_l_r > best_l_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      cur_l_r <= '0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
      cur_l_r <= '0;
    end else if (ctl.step) begin
      if (ctl.free_bit) begin
        cur_l_r <= cur_l_r + CNT_W'(1);
      end else begin
        if (take) begin
          found_r <= 1'b1;
        end
        cur_l_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && !ctl.clear) begin
      if (ctl.free_bit) begin
        if (cur_l_r == '0) begin
          cur_s_r <= pos;
        end
      end else if (take) begin
        best_s_r <= cur_s_r;
        best_l_r <= cur_l_r;
      end
    end
  end

  assign run.found = found_r;
  assign run.start = best_s_r;
  assign run.len   = best_l_r;

endmodule
`default_nettype wire

FILE: rtl/block_range_allocator.sv
// Top level of the contiguous block range allocator.
//
//   channel | direction | ports                                        | handshake
//   in      | input     | in_opcode, in_request_size, in_range_start   | in_valid / in_stall
//   out     | output    | out_status, out_granted_start, out_granted_count | out_valid / out_stall
//
// A valid request takes one scan pass over the map and, when it changes the map, one
// update pass over the map. Rejected requests end after the scan; a bad size or an
// out-of-range free skips the scan and goes straight to the result. The map rotates
// one bit per cycle through a shift register during each pass.
// Synchronous reset marks every block free.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module block_range_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire bra_pkg::opcode_t            in_opcode,
  input  wire logic [bra_pkg::CNT_W-1:0]   in_request_size,
  input  wire logic [bra_pkg::IDX_W-1:0]   in_range_start,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bra_pkg::status_t                 out_status,
  output logic [bra_pkg::IDX_W-1:0]        out_granted_start,
  output logic [bra_pkg::CNT_W-1:0]        out_granted_count
);
  import bra_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [CNT_W-1:0] POS_END  = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] POS_EVAL = CNT_W'(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(NUM_BLOCKS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  opcode_t          op_r;
  logic [CNT_W-1:0] size_r;
  logic [CNT_W-1:0] upd_lo_r, upd_hi_r;
  logic             ovl_r;
  status_t          res_status_r;
  logic [IDX_W-1:0] res_gstart_r;
  logic [CNT_W-1:0] res_gcount_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [IDX_W-1:0] out_gstart_r;
  logic [CNT_W-1:0] out_gcount_r;

  logic             accept;
  logic             size_bad;
  logic [CNT_W:0]   free_end;
  logic             free_oob;
  logic             in_map;
  logic             in_rng;
  logic             head_bit;
  logic             map_shift;
  logic             map_wr;
  logic             out_load;
  logic [CNT_W-1:0] spare;
  logic [CNT_W-1:0] grant;
  scan_ctl_t        scan_ctl;
  run_t             run;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign size_bad = (in_request_size == '0) || (in_request_size > MAX_REQUEST);
  assign free_end = {1'b0, {1'b0, in_range_start}} + {1'b0, in_request_size};
  assign free_oob = (free_end > (CNT_W + 1)'(NUM_BLOCKS));

  assign in_map = (pos_r < POS_END);
  assign in_rng = (pos_r >= upd_lo_r) && (pos_r < upd_hi_r);

  assign spare = run.len - size_r;
  assign grant = (spare > SPARE_LIMIT) ? size_r : run.len;

  always_comb begin
    map_shift = 1'b0;
    map_wr    = head_bit;
    case (state_r)
      S_SCAN: begin
        map_shift = in_map;
      end
      S_UPDATE: begin
        map_shift = 1'b1;
        if (in_rng) begin
          map_wr = (op_r == OP_FREE);
        end
      end
      default: begin
        map_shift = 1'b0;
      end
    endcase
  end

  assign scan_ctl.clear    = accept;
  assign scan_ctl.step     = (state_r == S_SCAN) && (pos_r <= POS_END);
  assign scan_ctl.free_bit = in_map && head_bit;

  bra_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (map_shift),
    .wr_bit   (map_wr),
    .head_bit (head_bit)
  );

  bra_runs u_runs (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .mode  (op_r),
    .need  (size_r),
    .pos   (pos_r[IDX_W-1:0]),
    .run   (run)
  );

  assign out_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt = '0;
          if (size_bad || ((in_opcode == OP_FREE) && free_oob)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pos_nxt = pos_r + CNT_W'(1);
        if (pos_r == POS_EVAL) begin
          pos_nxt = '0;
          if (op_r == OP_FREE) begin
            state_nxt = ovl_r ? S_FINISH : S_UPDATE;
          end else begin
            state_nxt = run.found ? S_UPDATE : S_FINISH;
          end
        end
      end
      S_UPDATE: begin
        pos_nxt = pos_r + CNT_W'(1);
        if (pos_r == POS_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      ovl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (accept) begin
        ovl_r <= 1'b0;
      end else if ((state_r == S_SCAN) && in_map && in_rng && head_bit) begin
        ovl_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and result bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_opcode;
      size_r       <= in_request_size;
      upd_lo_r     <= {1'b0, in_range_start};
      upd_hi_r     <= free_end[CNT_W-1:0];
      res_gstart_r <= '0;
      res_gcount_r <= '0;
      if (size_bad) begin
        res_status_r <= ST_BAD_SIZE;
      end else if ((in_opcode == OP_FREE) && free_oob) begin
        res_status_r <= ST_BAD_FREE;
      end else begin
        res_status_r <= ST_OK;
      end
    end else if ((state_r == S_SCAN) && (pos_r == POS_EVAL)) begin
      if (op_r == OP_FREE) begin
        res_status_r <= ovl_r ? ST_BAD_FREE : ST_OK;
      end else if (!run.found) begin
        res_status_r <= ST_NO_SPACE;
      end else begin
        res_status_r <= ST_OK;
        res_gstart_r <= run.start;
        res_gcount_r <= grant;
        upd_lo_r     <= {1'b0, run.start};
        upd_hi_r     <= {1'b0, run.start} + grant;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_gstart_r <= res_gstart_r;
      out_gcount_r <= res_gcount_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_gstart_r;
  assign out_granted_count = out_gcount_r;

  a_count_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_gcount_r != '0)) |-> (out_status_r == ST_OK))
    else $error("granted count on a failed request");

  a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_gcount_r != '0)) |->
    (({1'b0, {1'b0, out_gstart_r}} + {1'b0, out_gcount_r}) <= (CNT_W + 1)'(NUM_BLOCKS)))
    else $error("granted range runs past the pool");

  a_update_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPDATE) && ($past(state_r) == S_SCAN)) |->
    $past((op_r == OP_FREE && !ovl_r) || (op_r != OP_FREE && run.found)))
    else $error("map update without a fitting run or a clean free");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pos_r <= POS_EVAL))
    else $error("scan position past the end of the pass");

endmodule
`default_nettype wire

FILE: sim/bra_checker.sv
// Checker for the block range allocator: predicts each reply and compares it field by field.
`timescale 1ns / 1ps
module bra_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  bra_pkg::opcode_t               in_opcode,
  input  logic [bra_pkg::CNT_W-1:0]      in_request_size,
  input  logic [bra_pkg::IDX_W-1:0]      in_range_start,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  bra_pkg::status_t               out_status,
  input  logic [bra_pkg::IDX_W-1:0]      out_granted_start,
  input  logic [bra_pkg::CNT_W-1:0]      out_granted_count,
  output int                             errors,
  output int                             pending
);
  import bra_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
  } reply_t;

  bit [NUM_BLOCKS-1:0] free_map;
  reply_t              expected_replies[$];
  int                  replies_seen;

  initial begin
    errors       = 0;
    pending      = 0;
    replies_seen = 0;
    free_map     = '1;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Apply one request to the free map and return the reply it produces.
  function automatic reply_t serve_request(opcode_t op, logic [CNT_W-1:0] size,
                                           logic [IDX_W-1:0] first);
    reply_t r;
    int     cur_s, cur_l, best_s, best_l, grant;
    bit     found, take;
    r      = '{status: ST_OK, start: '0, count: '0};
    cur_s  = 0;
    cur_l  = 0;
    best_s = 0;
    best_l = 0;
    found  = 1'b0;
    take   = 1'b0;
    if (size == 0 || size > MAX_REQUEST) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    if (op == OP_FREE) begin
      if (int'(first) + int'(size) > NUM_BLOCKS) begin
        r.status = ST_BAD_FREE;
        return r;
      end
      for (int i = int'(first); i < int'(first) + int'(size); i++) begin
        if (free_map[i]) begin
          r.status = ST_BAD_FREE;
          return r;
        end
      end
      for (int i = int'(first); i < int'(first) + int'(size); i++) free_map[i] = 1'b1;
      return r;
    end
    // Scan one position past the end so that a run reaching the last block closes.
    for (int i = 0; i <= NUM_BLOCKS; i++) begin
      if (i < NUM_BLOCKS && free_map[i]) begin
        if (cur_l == 0) cur_s = i;
        cur_l++;
      end else begin
        if (cur_l >= int'(size)) begin
          if (!found) take = 1'b1;
          else if (op == OP_BEST) take = (cur_l < best_l);
          else if (op == OP_WORST) take = (cur_l > best_l);
          else take = 1'b0;
          if (take) begin
            best_s = cur_s;
            best_l = cur_l;
            found  = 1'b1;
          end
          if (op == OP_FIRST) break;
        end
        cur_l = 0;
      end
    end
    if (!found) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    // Hand out the whole run when the leftover would be too small to keep.
    grant = (best_l - int'(size) > int'(SPARE_LIMIT)) ? int'(size) : best_l;
    for (int i = best_s; i < best_s + grant && i < NUM_BLOCKS; i++) free_map[i] = 1'b0;
    r.start = best_s[IDX_W-1:0];
    r.count = grant[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      free_map = '1;
      expected_replies.delete();
    end else begin
      // Retire the reply first: an item taken at this edge cannot answer at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d with no request waiting: status %0d",
                                    replies_seen, out_status));
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("reply %0d: status %0d, expected %0d",
                                      replies_seen, out_status, want.status));
          if (out_granted_start !== want.start)
            report_mismatch($sformatf("reply %0d: granted_start %0d, expected %0d",
                                      replies_seen, out_granted_start, want.start));
          if (out_granted_count !== want.count)
            report_mismatch($sformatf("reply %0d: granted_count %0d, expected %0d",
                                      replies_seen, out_granted_count, want.count));
        end
        replies_seen++;
      end
      if (in_valid && !in_stall)
        expected_replies.push_back(serve_request(in_opcode, in_request_size, in_range_start));
    end
    pending <= expected_replies.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the allocator testbench: clock, reset, request stimulus, reply stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import bra_pkg::*;

  localparam int RANDOM_ITEMS    = 750;
  localparam int HOLD_OFF_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 600;
  localparam int CYCLE_LIMIT     = 4_000_000;

  typedef enum {FLOW, CHOPPY, BLOCKED} stall_mode_t;

  typedef struct {
    int start;
    int count;
  } held_range_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  opcode_t            in_opcode;
  logic [CNT_W-1:0]   in_request_size;
  logic [IDX_W-1:0]   in_range_start;
  logic               out_valid;
  logic               out_stall;
  status_t            out_status;
  logic [IDX_W-1:0]   out_granted_start;
  logic [CNT_W-1:0]   out_granted_count;

  int                 errors;
  int                 pending;
  int                 accepted_items;
  int                 cycle_count;
  int                 burst_left;
  bit                 track_grants;

  // Ranges handed out during the random phase, used to build well-formed frees.
  held_range_t        held_ranges[$];
  logic               grant_seen;
  logic [IDX_W-1:0]   grant_start_q;
  logic [CNT_W-1:0]   grant_count_q;

  block_range_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_request_size   (in_request_size),
    .in_range_start    (in_range_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_start (out_granted_start),
    .out_granted_count (out_granted_count)
  );

  bra_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_request_size   (in_request_size),
    .in_range_start    (in_range_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_start (out_granted_start),
    .out_granted_count (out_granted_count),
    .errors            (errors),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    accepted_items = 0;
    burst_left     = 0;
    track_grants   = 1'b0;
    grant_seen     = 1'b0;
    grant_start_q  = '0;
    grant_count_q  = '0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) accepted_items <= accepted_items + 1;
  end

  // Capture grants at the rising edge and queue them on the falling edge.
  always @(posedge clk) begin
    grant_seen    <= rst_n && track_grants && out_valid && !out_stall &&
                     out_status == ST_OK && out_granted_count != 0;
    grant_start_q <= out_granted_start;
    grant_count_q <= out_granted_count;
  end

  always @(negedge clk) begin
    if (grant_seen)
      held_ranges.push_back('{start: int'(grant_start_q), count: int'(grant_count_q)});
  end

  // Hold the item until the block takes it.
  task automatic offer(input opcode_t op, input logic [CNT_W-1:0] size,
                       input logic [IDX_W-1:0] first);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_request_size <= size;
    in_range_start  <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send in bursts; drop valid for a random gap between them.
  task automatic pace();
    int roll, gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 7);
    roll = $urandom_range(0, 99);
    if (roll < 50) gap = 0;
    else if (roll < 80) gap = $urandom_range(1, 5);
    else if (roll < 95) gap = $urandom_range(6, 60);
    else gap = $urandom_range(200, 700);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request();
    int          roll, idx, piece;
    held_range_t hr;
    logic [CNT_W-1:0] size;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      // Noise: any opcode, any 9-bit size, any start.
      offer(opcode_t'($urandom_range(0, 3)), CNT_W'($urandom_range(0, 511)),
            IDX_W'($urandom_range(0, 255)));
    end else if (roll < 55 && held_ranges.size() > 0) begin
      idx = $urandom_range(0, held_ranges.size() - 1);
      hr  = held_ranges[idx];
      held_ranges.delete(idx);
      // Sometimes return only the front of a range and keep the rest.
      if (hr.count > 1 && $urandom_range(0, 3) == 0) begin
        piece = $urandom_range(1, hr.count - 1);
        held_ranges.push_back('{start: hr.start + piece, count: hr.count - piece});
        hr.count = piece;
      end
      offer(OP_FREE, CNT_W'(hr.count), IDX_W'(hr.start));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) size = CNT_W'($urandom_range(1, 16));
      else if (roll < 90) size = CNT_W'($urandom_range(17, 64));
      else size = CNT_W'($urandom_range(65, 256));
      offer(opcode_t'($urandom_range(0, 2)), size, IDX_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : sender
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_FIRST;
    in_request_size <= '0;
    in_range_start  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad sizes, frees on an all-free pool, out-of-range free.
    offer(OP_FIRST, 9'd0,   8'd0);    pace();
    offer(OP_WORST, 9'd511, 8'd255);  pace();
    offer(OP_FREE,  9'd1,   8'd0);    pace();
    offer(OP_FREE,  9'd2,   8'd255);  pace();
    // Whole pool, then a grant that swallows a one-block leftover.
    offer(OP_FIRST, 9'd256, 8'd0);    pace();
    offer(OP_FREE,  9'd256, 8'd0);    pace();
    offer(OP_FIRST, 9'd255, 8'd77);   pace();
    // Carve out free runs, block 0 among them.
    offer(OP_FREE,  9'd1,   8'd0);    pace();
    offer(OP_FREE,  9'd56,  8'd200);  pace();
    offer(OP_FREE,  9'd10,  8'd100);  pace();
    offer(OP_BEST,  9'd5,   8'd0);    pace();
    offer(OP_WORST, 9'd3,   8'd0);    pace();
    offer(OP_FIRST, 9'd1,   8'd0);    pace();
    offer(OP_BEST,  9'd4,   8'd0);    pace();
    // Merge with a free neighbor, then a partial overlap and no space.
    offer(OP_FREE,  9'd3,   8'd0);    pace();
    offer(OP_FREE,  9'd3,   8'd3);    pace();
    offer(OP_FREE,  9'd2,   8'd5);    pace();
    offer(OP_FIRST, 9'd60,  8'd0);    pace();
    // Ties in best and worst fit.
    offer(OP_FREE,  9'd6,   8'd10);   pace();
    offer(OP_BEST,  9'd6,   8'd0);    pace();
    offer(OP_FREE,  9'd53,  8'd100);  pace();
    offer(OP_WORST, 9'd1,   8'd0);    pace();
    // Return everything still allocated so the random part starts on a full pool.
    offer(OP_FREE,  9'd10,  8'd0);    pace();
    offer(OP_FREE,  9'd84,  8'd16);   pace();
    offer(OP_FREE,  9'd1,   8'd100);  pace();
    offer(OP_FREE,  9'd50,  8'd153);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    track_grants = 1'b1;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      random_request();
      pace();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : receiver
    stall_mode_t mode;
    int          len, hold_offs;
    hold_offs = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_offs < 2 && accepted_items >= 60 + 300 * hold_offs) begin
        // Long hold-off: let the block fill up and stall its input.
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs++;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 2));
        case (mode)
          FLOW:    len = $urandom_range(1, 600);
          CHOPPY:  len = $urandom_range(1, 300);
          default: len = $urandom_range(1, 40);
        endcase
        repeat (len) begin
          case (mode)
            FLOW:    out_stall <= 1'b0;
            CHOPPY:  out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
